### design/knncd_pkg.sv
// Shared types and constants for the nearest-neighbor class-distance classifier.
`timescale 1ns / 1ps
package knncd_pkg;

	localparam int FEATURE_COUNT = 9;
	localparam int TABLE_DEPTH   = 1024;
	localparam int CLASS_COUNT   = 16;
	localparam int NEIGHBORS_K   = 5;

	localparam int FEAT_W   = 32;
	localparam int DIST_W   = 64;
	localparam int LABEL_W  = 4;
	localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int CLS_W    = $clog2(CLASS_COUNT);
	localparam int HIT_W    = $clog2(NEIGHBORS_K + 1);
	localparam int FI_W     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int ROW_W    = FEATURE_COUNT * FEAT_W + LABEL_W;

	localparam logic [FEAT_W-1:0] ONE_Q16 = 32'h0001_0000;

	typedef logic [FEATURE_COUNT-1:0][FEAT_W-1:0] feat_vec_t;
	typedef logic [NEIGHBORS_K-1:0][DIST_W-1:0]   dist_row_t;

	typedef enum logic [1:0] {
		CMD_SET_DEV  = 2'd0,
		CMD_ADD_REF  = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_RROW,
		ST_INS,
		ST_SUM_RD,
		ST_SUM,
		ST_DONE
	} state_t;

	// request to the per-class neighbor memory
	typedef struct packed {
		logic                rd_en;
		logic                ins_en;
		logic [CLS_W-1:0]    addr;
		logic [HIT_W-1:0]    hits;
		logic [DIST_W-1:0]   dist_val;
	} cls_req_t;

endpackage

### design/knn_class_distance_classifier_unit.sv
// Top level of the nearest-neighbor class-distance classifier.
//
// Requests arrive on the s_ side: s_tuser carries the command (set deviations,
// add reference, classify, clear), s_tdata the nine Q16.16 features and the
// label. Every request gives exactly one result on the m_ side: m_tuser holds
// the status, m_tdata the winning class and its Q32.32 distance sum.
// One request is worked on at a time; s_tready is high only while idle.
// Set deviations, add and clear go straight to the result. For every stored
// reference a query does a fetch and load, a 32-step divider lane per feature,
// then one shared 32x32 multiplier and accumulate over the nine features and a
// read-insert-write of the class row; it ends with the final sum per class.
// The table holds up to 1024 entries.
// The result sits in an output register; the next request is accepted while
// it waits, and a further result waits until the receiver takes the first.
// Reset empties the table, sets every deviation to 1.0 and drops any result.
// The reference memory needs no clearing: only written entries are read.
`timescale 1ns / 1ps
module knn_class_distance_classifier_unit
	import knncd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [295:0] s_tdata,   // feature_0 .. feature_8 (32 each), label (4), zero pad
	input  logic [1:0]   s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // best_class (4), best_sum (64), zero pad
	output logic [1:0]   m_tuser    // status
);

	state_t state_q, state_d;

	feat_vec_t                      devs_q;
	feat_vec_t                      query_q;
	feat_vec_t                      in_feat;
	logic [LABEL_W-1:0]             in_label;
	cmd_t                           in_cmd;
	logic                           acc;

	logic [CNT_W-1:0]               count_q;
	logic [ADDR_W-1:0]              e_q;
	logic [FI_W-1:0]                fi_q;
	logic [CLS_W-1:0]               c_q;
	logic [HIT_W-1:0]               j_q;
	logic [CLASS_COUNT-1:0][HIT_W-1:0] hits_q;
	logic [LABEL_W-1:0]             lab_q;
	logic [DIST_W-1:0]              prod_q;
	logic [DIST_W-1:0]              sum_q;
	logic [DIST_W-1:0]              best_q;
	logic [CLS_W-1:0]               best_cls_q;
	logic                           found_q;

	status_t                        res_status_q;
	logic [LABEL_W-1:0]             res_cls_q;
	logic [DIST_W-1:0]              res_sum_q;
	logic                           out_valid_q;
	status_t                        out_status_q;
	logic [LABEL_W-1:0]             out_cls_q;
	logic [DIST_W-1:0]              out_sum_q;

	// unpack request
	always_comb begin
		for (int i = 0; i < FEATURE_COUNT; i++) begin
			in_feat[i] = s_tdata[i*FEAT_W +: FEAT_W];
		end
	end
	assign in_label = s_tdata[288 +: LABEL_W];
	assign in_cmd   = cmd_t'(s_tuser);
	assign acc      = s_tvalid && s_tready;

	// reference table
	logic              ref_we, ref_re;
	logic [ROW_W-1:0]  ref_row;
	feat_vec_t         ref_feat;
	logic [LABEL_W-1:0] ref_label;
	logic              last_entry;

	knncd_ref_mem u_ref_mem (
		.clk   (clk),
		.we    (ref_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({in_label, in_feat}),
		.re    (ref_re),
		.raddr (e_q),
		.rdata (ref_row)
	);

	assign ref_feat  = ref_row[FEATURE_COUNT*FEAT_W-1:0];
	assign ref_label = ref_row[ROW_W-1 -: LABEL_W];
	assign last_entry = (CNT_W'(e_q) + CNT_W'(1)) == count_q;

	// divider lanes
	feat_vec_t                ratio;
	logic [FEATURE_COUNT-1:0] rsat;
	logic                     div_start, div_done;
	logic                     lab_ok;

	assign lab_ok = {1'b0, ref_label} < (LABEL_W+1)'(CLASS_COUNT);

	knncd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.query  (query_q),
		.refv   (ref_feat),
		.devs   (devs_q),
		.ratio  (ratio),
		.sat    (rsat),
		.done   (div_done)
	);

	// distance accumulator
	logic [DIST_W-1:0] ref_dist;
	logic              acc_clear, acc_add;

	knncd_acc u_acc (
		.clk   (clk),
		.clear (acc_clear),
		.add   (acc_add),
		.term  (prod_q),
		.total (ref_dist)
	);

	// per-class neighbor rows
	cls_req_t  creq;
	dist_row_t crow;
	logic [CLS_W-1:0] lab_idx;

	assign lab_idx = lab_q[CLS_W-1:0];

	knncd_class_mem u_class_mem (
		.clk (clk),
		.req (creq),
		.row (crow)
	);

	// class sum step
	logic [DIST_W:0] sum_next;
	assign sum_next = {1'b0, sum_q} + {1'b0, crow[j_q]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_cmd == CMD_QUERY) begin
						state_d = (count_q == '0) ? ST_SUM_RD : ST_FETCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FETCH:  state_d = ST_LOAD;
			ST_LOAD: begin
				if (lab_ok) begin
					state_d = ST_DIV;
				end else begin
					state_d = last_entry ? ST_SUM_RD : ST_FETCH;
				end
			end
			ST_DIV:    state_d = div_done ? ST_MUL : ST_DIV;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = (fi_q == FI_W'(FEATURE_COUNT - 1)) ? ST_RROW : ST_MUL;
			ST_RROW:   state_d = ST_INS;
			ST_INS:    state_d = last_entry ? ST_SUM_RD : ST_FETCH;
			ST_SUM_RD: state_d = ST_SUM;
			ST_SUM: begin
				if (j_q == hits_q[c_q]) begin
					state_d = (c_q == CLS_W'(CLASS_COUNT - 1)) ? ST_DONE : ST_SUM_RD;
				end
			end
			ST_DONE:   state_d = (!out_valid_q || m_tready) ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		ref_we     = acc && (in_cmd == CMD_ADD_REF) && (count_q != CNT_W'(TABLE_DEPTH));
		ref_re     = (state_q == ST_FETCH);
		div_start  = (state_q == ST_LOAD) && lab_ok;
		acc_clear  = (state_q == ST_LOAD);
		acc_add    = (state_q == ST_ACC);
		creq.rd_en  = (state_q == ST_RROW) || (state_q == ST_SUM_RD);
		creq.ins_en = (state_q == ST_INS);
		creq.addr   = (state_q == ST_SUM_RD) ? c_q : lab_idx;
		creq.hits   = hits_q[lab_idx];
		creq.dist_val = ref_dist;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FEATURE_COUNT; i++) begin
				devs_q[i] <= ONE_Q16;
			end
		end else begin
			state_q <= state_d;
			if (acc) begin
				unique case (in_cmd)
					CMD_SET_DEV: devs_q <= in_feat;
					CMD_ADD_REF: begin
						if (count_q != CNT_W'(TABLE_DEPTH)) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					CMD_CLEAR:   count_q <= '0;
					CMD_QUERY:   ;
					default:     ;
				endcase
			end
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				query_q      <= in_feat;
				e_q          <= '0;
				c_q          <= '0;
				found_q      <= 1'b0;
				hits_q       <= '0;
				res_cls_q    <= '0;
				res_sum_q    <= '0;
				res_status_q <= (acc && in_cmd == CMD_ADD_REF &&
					count_q == CNT_W'(TABLE_DEPTH)) ? STAT_FULL : STAT_DONE;
			end
			ST_LOAD: begin
				lab_q <= ref_label;
				fi_q  <= '0;
				if (!lab_ok && !last_entry) begin
					e_q <= e_q + ADDR_W'(1);
				end
			end
			ST_MUL: begin
				prod_q <= rsat[fi_q] ? '1 : (DIST_W'(ratio[fi_q]) * DIST_W'(ratio[fi_q]));
			end
			ST_ACC: fi_q <= fi_q + FI_W'(1);
			ST_INS: begin
				if (hits_q[lab_idx] != HIT_W'(NEIGHBORS_K)) begin
					hits_q[lab_idx] <= hits_q[lab_idx] + HIT_W'(1);
				end
				if (!last_entry) begin
					e_q <= e_q + ADDR_W'(1);
				end
			end
			ST_SUM_RD: begin
				sum_q <= '0;
				j_q   <= '0;
			end
			ST_SUM: begin
				if (j_q != hits_q[c_q]) begin
					sum_q <= sum_next[DIST_W] ? '1 : sum_next[DIST_W-1:0];
					j_q   <= j_q + HIT_W'(1);
				end else begin
					if (hits_q[c_q] != '0 && (!found_q || sum_q < best_q)) begin
						found_q    <= 1'b1;
						best_q     <= sum_q;
						best_cls_q <= c_q;
					end
					c_q <= c_q + CLS_W'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_status_q <= res_status_q;
					out_cls_q    <= res_cls_q;
					out_sum_q    <= res_sum_q;
				end
			end
			default: ;
		endcase
		// query verdict once the last class is scored
		if (state_q == ST_SUM && state_d == ST_DONE) begin
			if (hits_q[c_q] != '0 && (!found_q || sum_q < best_q)) begin
				res_status_q <= STAT_DONE;
				res_cls_q    <= LABEL_W'(c_q);
				res_sum_q    <= sum_q;
			end else if (found_q) begin
				res_status_q <= STAT_DONE;
				res_cls_q    <= LABEL_W'(best_cls_q);
				res_sum_q    <= best_q;
			end else begin
				res_status_q <= STAT_EMPTY;
				res_cls_q    <= '0;
				res_sum_q    <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'd0, out_sum_q, out_cls_q};

endmodule

### design/knncd_ref_mem.sv
// Reference table memory: one row holds all features and the label of an entry.
`timescale 1ns / 1ps
module knncd_ref_mem
	import knncd_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [ROW_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [ROW_W-1:0]  rdata
);

	logic [ROW_W-1:0] mem [TABLE_DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/knncd_div.sv
// Per-feature lanes of restoring dividers giving floor(|q-r| * 2^16 / |dev|).
`timescale 1ns / 1ps
module knncd_div
	import knncd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  feat_vec_t                query,
	input  feat_vec_t                refv,
	input  feat_vec_t                devs,
	output feat_vec_t                ratio,
	output logic [FEATURE_COUNT-1:0] sat,
	output logic                     done
);

	logic [5:0]                      step_q;
	logic                            busy_q;
	logic [FEATURE_COUNT-1:0][31:0]  rem_q;
	logic [FEATURE_COUNT-1:0][31:0]  shf_q;   // dividend bits out the top, quotient in
	logic [FEATURE_COUNT-1:0][31:0]  dv_q;
	logic [FEATURE_COUNT-1:0]        sat_q;

	// operand preparation per lane
	logic [FEATURE_COUNT-1:0][32:0]  dabs;
	logic [FEATURE_COUNT-1:0][31:0]  vabs;
	logic [FEATURE_COUNT-1:0]        lane_sat;
	logic signed [32:0]              diff;
	logic signed [32:0]              sdev;

	always_comb begin
		diff = '0;
		sdev = '0;
		for (int i = 0; i < FEATURE_COUNT; i++) begin
			diff = {query[i][31], query[i]} - {refv[i][31], refv[i]};
			sdev = {devs[i][31], devs[i]};
			dabs[i] = diff[32] ? 33'(-diff) : 33'(diff);
			vabs[i] = sdev[32] ? 32'(-sdev) : 32'(sdev);
			lane_sat[i] = (vabs[i] == '0) || ({15'd0, dabs[i]} >= {vabs[i], 16'd0});
		end
	end

	// one quotient bit per lane per cycle while busy
	logic [FEATURE_COUNT-1:0][32:0] trial;
	always_comb begin
		for (int i = 0; i < FEATURE_COUNT; i++) begin
			trial[i] = {rem_q[i], shf_q[i][31]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 6'd1;
			if (step_q == 6'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FEATURE_COUNT; i++) begin
			if (start) begin
				rem_q[i] <= {15'd0, dabs[i][32:16]};
				shf_q[i] <= {dabs[i][15:0], 16'd0};
				dv_q[i]  <= vabs[i];
				sat_q[i] <= lane_sat[i];
			end else if (busy_q) begin
				if (trial[i] >= {1'b0, dv_q[i]}) begin
					rem_q[i] <= 32'(trial[i] - {1'b0, dv_q[i]});
					shf_q[i] <= {shf_q[i][30:0], 1'b1};
				end else begin
					rem_q[i] <= trial[i][31:0];
					shf_q[i] <= {shf_q[i][30:0], 1'b0};
				end
			end
		end
	end

	assign ratio = shf_q;
	assign sat   = sat_q;
	assign done  = busy_q && (step_q == 6'd31);

endmodule

### design/knncd_class_mem.sv
// Per-class memory of the K smallest distances, kept sorted by read-insert-write.
`timescale 1ns / 1ps
module knncd_class_mem
	import knncd_pkg::*;
(
	input  logic      clk,
	input  cls_req_t  req,
	output dist_row_t row
);

	dist_row_t mem [CLASS_COUNT];
	dist_row_t ins_row;
	logic [HIT_W-1:0] pos;

	// insertion point: after every held entry not above the new distance
	always_comb begin
		pos = '0;
		for (int j = 0; j < NEIGHBORS_K; j++) begin
			if ((HIT_W'(j) < req.hits) && (row[j] <= req.dist_val)) begin
				pos = pos + HIT_W'(1);
			end
		end
		for (int j = 0; j < NEIGHBORS_K; j++) begin
			if (HIT_W'(j) < pos) begin
				ins_row[j] = row[j];
			end else if (HIT_W'(j) == pos) begin
				ins_row[j] = req.dist_val;
			end else begin
				ins_row[j] = row[(j > 0) ? j - 1 : 0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ins_en) begin
			mem[req.addr] <= ins_row;
		end
		if (req.rd_en) begin
			row <= mem[req.addr];
		end
	end

endmodule

### design/knncd_top_unused_guard.sv
// Saturating distance accumulator: adds one per-feature term whenever add is high.
`timescale 1ns / 1ps
module knncd_acc
	import knncd_pkg::*;
(
	input  logic              clk,
	input  logic              clear,
	input  logic              add,
	input  logic [DIST_W-1:0] term,
	output logic [DIST_W-1:0] total
);

	logic [DIST_W:0] sum;

	assign sum = {1'b0, total} + {1'b0, term};

	always_ff @(posedge clk) begin
		if (clear) begin
			total <= '0;
		end else if (add) begin
			total <= sum[DIST_W] ? '1 : sum[DIST_W-1:0];
		end
	end

endmodule

### bench/tb_top.sv
// Self-checking bench for the nearest-neighbor class-distance classifier.
`timescale 1ns / 1ps
module tb_top;
	import knncd_pkg::*;

	typedef struct {
		cmd_t                  cmd;
		logic [8:0][31:0]      feat;
		logic [3:0]            label;
		bit                    drain;
	} request_t;

	typedef struct {
		status_t      status;
		logic [3:0]   cls;
		logic [63:0]  sum;
	} verdict_t;

	localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [295:0] s_tdata;   // feature_0 .. feature_8 (32 each), label (4), zero pad
	logic [1:0]   s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;   // best_class (4), best_sum (64), zero pad
	logic [1:0]   m_tuser;   // status

	request_t  pending_reqs[$];
	verdict_t  expected_verdicts[$];
	int        fail_count = 0;
	bit        took = 0;
	int        gap_left = 0;
	int        burst_left = 1;
	int        cyc = 0;
	int        stall_mode = 0;

	// bench copy of the classifier state
	logic [31:0]       dev_reg[9];
	logic [31:0]       ref_feat[TABLE_DEPTH][9];
	logic [3:0]        ref_lab[TABLE_DEPTH];
	int                ref_count;
	logic [63:0]       nearest[CLASS_COUNT][NEIGHBORS_K];
	int                hit_count[CLASS_COUNT];

	knn_class_distance_classifier_unit dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// append a request to the stimulus queue
	function automatic void queue_req(request_t rq);
		pending_reqs.insert(pending_reqs.size(), rq);
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? SAT : s[63:0];
	endfunction

	// scaled squared difference of one feature
	function automatic logic [63:0] term(logic [31:0] q, logic [31:0] r, logic [31:0] dv);
		longint diff, sdev;
		logic [63:0] d, v, ratio;
		diff = longint'($signed(q)) - longint'($signed(r));
		sdev = longint'($signed(dv));
		d = (diff < 0) ? -diff : diff;
		v = (sdev < 0) ? -sdev : sdev;
		if (v == 0) return SAT;
		ratio = (d << 16) / v;
		if (ratio > 64'hFFFF_FFFF) return SAT;
		return ratio * ratio;
	endfunction

	function automatic void insert_nearest(int c, logic [63:0] new_dist);
		int pos;
		if (hit_count[c] < NEIGHBORS_K) begin
			pos = hit_count[c];
			hit_count[c]++;
		end else if (new_dist < nearest[c][NEIGHBORS_K-1]) begin
			pos = NEIGHBORS_K - 1;
		end else begin
			return;
		end
		while (pos > 0 && nearest[c][pos-1] > new_dist) begin
			nearest[c][pos] = nearest[c][pos-1];
			pos--;
		end
		nearest[c][pos] = new_dist;
	endfunction

	// apply one request to the bench state and give its result
	function automatic verdict_t classify_step(request_t rq);
		verdict_t vd;
		logic [63:0] ref_dist, total;
		bit found;
		vd.status = STAT_DONE;
		vd.cls = '0;
		vd.sum = '0;
		case (rq.cmd)
			CMD_SET_DEV: for (int i = 0; i < 9; i++) dev_reg[i] = rq.feat[i];
			CMD_ADD_REF: begin
				if (ref_count >= TABLE_DEPTH) begin
					vd.status = STAT_FULL;
				end else begin
					for (int i = 0; i < 9; i++) ref_feat[ref_count][i] = rq.feat[i];
					ref_lab[ref_count] = rq.label;
					ref_count++;
				end
			end
			CMD_CLEAR: ref_count = 0;
			default: begin
				found = 0;
				for (int c = 0; c < CLASS_COUNT; c++) hit_count[c] = 0;
				for (int e = 0; e < ref_count; e++) begin
					ref_dist = '0;
					for (int i = 0; i < FEATURE_COUNT; i++)
						ref_dist = sat_sum(ref_dist, term(rq.feat[i], ref_feat[e][i], dev_reg[i]));
					insert_nearest(int'(ref_lab[e]), ref_dist);
				end
				for (int c = 0; c < CLASS_COUNT; c++) begin
					if (hit_count[c] != 0) begin
						total = '0;
						for (int i = 0; i < hit_count[c]; i++)
							total = sat_sum(total, nearest[c][i]);
						if (!found || total < vd.sum) begin
							found = 1;
							vd.sum = total;
							vd.cls = 4'(c);
						end
					end
				end
				if (!found) vd.status = STAT_EMPTY;
			end
		endcase
		return vd;
	endfunction

	function automatic logic [31:0] rand_feature();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_deviation();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return $urandom;
			2: return -($urandom_range(1, 32'h0004_0000));
			3: return 32'h1;
			default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
		endcase
	endfunction

	function automatic request_t make_req(cmd_t cmd);
		request_t rq;
		rq.cmd = cmd;
		rq.label = 4'($urandom_range(0, 15));
		rq.drain = 0;
		for (int i = 0; i < 9; i++) rq.feat[i] = rand_feature();
		return rq;
	endfunction

	// request driver: bursts with random gaps, optional drain points
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
				s_tvalid <= 1'b0;
				if (!s_tvalid && expected_verdicts.size() == 0) void'(pending_reqs.pop_front());
			end else if (pending_reqs.size() != 0) begin
				request_t rq;
				rq = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= rq.cmd;
				s_tdata <= {4'b0, rq.label, rq.feat};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern with four modes, the mode chosen at random
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= (cyc % 4 == 0);
			default: m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// acceptance tracking, prediction and result checking
	always @(posedge clk) begin
		request_t rq;
		verdict_t ex;
		took <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			rq.cmd = cmd_t'(s_tuser);
			rq.feat = s_tdata[287:0];
			rq.label = s_tdata[291:288];
			rq.drain = 0;
			expected_verdicts.insert(expected_verdicts.size(), classify_step(rq));
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result status=%0d", m_tuser);
				fail_count++;
			end else begin
				ex = expected_verdicts.pop_front();
				if (m_tuser !== ex.status) begin
					$error("status: expected %0d, actual %0d", ex.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[3:0] !== ex.cls) begin
					$error("best_class: expected %0d, actual %0d", ex.cls, m_tdata[3:0]);
					fail_count++;
				end
				if (m_tdata[67:4] !== ex.sum) begin
					$error("best_sum: expected %h, actual %h", ex.sum, m_tdata[67:4]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// stimulus and end of run
	initial begin
		request_t rq, base;
		request_t drain_rq;
		int n_items, n_refs;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = CMD_SET_DEV;
		m_tready = 0;
		for (int i = 0; i < 9; i++) dev_reg[i] = ONE_Q16;
		ref_count = 0;
		drain_rq = make_req(CMD_CLEAR);
		drain_rq.drain = 1;

		// directed: empty query, extremes, zero and negative deviation, labels 0, 5 and 15
		queue_req(make_req(CMD_QUERY));
		rq = make_req(CMD_ADD_REF);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h8000_0000;
		rq.label = 0;
		queue_req(rq);
		rq = make_req(CMD_ADD_REF);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h7FFF_FFFF;
		rq.label = 15;
		queue_req(rq);
		rq = make_req(CMD_QUERY);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h0;
		queue_req(rq);
		rq = make_req(CMD_QUERY);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h7FFF_FFFF;
		queue_req(rq);
		rq = make_req(CMD_SET_DEV);
		for (int i = 0; i < 9; i++) rq.feat[i] = (i == 3) ? 32'h0 : -32'sh0002_0000;
		queue_req(rq);
		queue_req(make_req(CMD_QUERY));
		rq = make_req(CMD_SET_DEV);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h8000_0000;
		queue_req(rq);
		queue_req(make_req(CMD_QUERY));
		rq = make_req(CMD_SET_DEV);
		for (int i = 0; i < 9; i++) rq.feat[i] = 32'h1;
		queue_req(rq);
		for (int k = 0; k < 7; k++) begin
			rq = make_req(CMD_ADD_REF);
			rq.label = 5;
			queue_req(rq);
		end
		queue_req(make_req(CMD_QUERY));
		queue_req(drain_rq);
		queue_req(make_req(CMD_CLEAR));
		queue_req(make_req(CMD_QUERY));
		n_items = pending_reqs.size();

		// random phases: deviations, a small labeled table, queries near entries
		while (n_items < 538) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_req(make_req(cmd_t'($urandom_range(0, 3))));
				n_items++;
				continue;
			end
			if ($urandom_range(0, 1)) queue_req(make_req(CMD_CLEAR));
			rq = make_req(CMD_SET_DEV);
			for (int i = 0; i < 9; i++) rq.feat[i] = rand_deviation();
			queue_req(rq);
			n_refs = $urandom_range(1, 20);
			base = make_req(CMD_ADD_REF);
			for (int k = 0; k < n_refs; k++) begin
				rq = make_req(CMD_ADD_REF);
				rq.label = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(0, 3));
				if ($urandom_range(0, 2) != 0)
					for (int i = 0; i < 9; i++)
						rq.feat[i] = base.feat[i] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
				queue_req(rq);
			end
			for (int k = $urandom_range(1, 4); k > 0; k--) begin
				rq = make_req(CMD_QUERY);
				if ($urandom_range(0, 3) != 0)
					for (int i = 0; i < 9; i++)
						rq.feat[i] = base.feat[i] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
				queue_req(rq);
				n_items++;
			end
			n_items += n_refs + 2;
			if ($urandom_range(0, 15) == 0) queue_req(drain_rq);
		end

		// closing: empty the table and query it
		queue_req(make_req(CMD_CLEAR));
		queue_req(make_req(CMD_QUERY));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
design/knncd_pkg.sv
design/knncd_ref_mem.sv
design/knncd_div.sv
design/knncd_class_mem.sv
design/knncd_top_unused_guard.sv
design/knn_class_distance_classifier_unit.sv
bench/tb_top.sv
